>>> rtl/core/sbc_pkg.sv
// ============================================================================
// sbc_pkg : shared types and constants for the stereo bitcrusher
// Sample, phase and divider widths, register indices and the lane job record.
// ============================================================================
package sbc_pkg;

    // Sample format: signed Q1.15, +FULL_SCALE stands for +1.0
    localparam int SAMPLE_W   = 16;
    localparam int FULL_SCALE = (2 ** (SAMPLE_W - 1)) - 1;

    // Phase, increment and mix: unsigned, PH_FRAC fraction bits
    localparam int PH_FRAC = 16;
    localparam int CFG_W   = PH_FRAC + 1;
    localparam int PHASE_W = PH_FRAC + 2;
    localparam logic [CFG_W-1:0] PH_ONE = CFG_W'(2 ** PH_FRAC);

    // Bit depth
    localparam int BITS_W    = 5;
    localparam int MAX_DEPTH = 16;
    localparam int LEVELS_W  = MAX_DEPTH;

    // Configuration register indices
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT = 2'd2;

    // Quantiser divider: 33-bit numerator, 17-bit divisor, 16-bit quotient
    localparam int NUM_W      = SAMPLE_W + LEVELS_W + 1;
    localparam int DEN_W      = SAMPLE_W + 1;
    localparam int QUOT_W     = SAMPLE_W;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_STEPS  = QUOT_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Blend product: 17-bit signed difference times 18-bit signed mix
    localparam int MIXP_W = SAMPLE_W + CFG_W + 2;

    // Number of channels worked side by side
    localparam int NUM_LANES = 2;

    // Per-request job handed to every lane
    typedef struct packed {
        logic                capture;
        logic [LEVELS_W-1:0] levels_m1;
        logic [CFG_W-1:0]    mix;
    } sbc_job_t;

endpackage

>>> rtl/core/sbc_div.sv
// ============================================================================
// sbc_div : iterative unsigned divider
// Restoring division, DIV_RADIX quotient bits per cycle. The caller guarantees
// that the quotient fits in QUOT_W bits.
// ============================================================================
module sbc_div
    import sbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic                 running_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [QUOT_W-1:0]    shift_reg;
    logic [QUOT_W-1:0]    shift_next;
    logic [DEN_W-1:0]     denom_reg;

    // DIV_RADIX restoring steps per cycle; numerator bits leave the top of the
    // shift register while quotient bits enter at the bottom
    always_comb begin
        logic [DEN_W:0] trial;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        for (int i = 0; i < DIV_RADIX; i++) begin
            trial      = {rem_next, shift_next[QUOT_W-1]};
            shift_next = {shift_next[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, denom_reg}) begin
                rem_next      = DEN_W'(trial - {1'b0, denom_reg});
                shift_next[0] = 1'b1;
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                running_reg <= 1'b1;
                count_reg   <= '0;
            end else if (running_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= numer[NUM_W-1:QUOT_W];
            shift_reg <= numer[QUOT_W-1:0];
            denom_reg <= denom;
        end else if (running_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign done = done_reg;
    assign quot = shift_reg;

endmodule

>>> rtl/core/sbc_lane.sv
// ============================================================================
// sbc_lane : one channel of the bitcrusher
// Optionally quantises and holds the sample (a level estimate by shifts and
// adds, then one iterative division), then blends the held value with the dry
// sample and keeps the result until the next request.
// ============================================================================
module sbc_lane
    import sbc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  sbc_job_t                   job,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int SH = SAMPLE_W - 1;

    typedef enum logic [3:0] {
        L_IDLE, L_MUL1, L_LVL1, L_LVL2, L_LVL3, L_MUL2, L_DIV2S, L_DIV2W, L_MIX1, L_MIX2
    } lane_state_t;

    lane_state_t state_reg, state_next;

    logic                       done_reg;
    sbc_job_t                   job_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;
    logic signed [SAMPLE_W-1:0] held_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [QUOT_W-1:0]          level_reg;
    logic [QUOT_W:0]            lvl_est_reg;
    logic [QUOT_W:0]            lvl_rem_reg;
    logic signed [MIXP_W-1:0]   mix_prod_reg;

    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           div_numer;
    logic [DEN_W-1:0]           div_denom;
    logic [QUOT_W-1:0]          div_quot;

    logic [SAMPLE_W-1:0]        u_val;
    logic [QUOT_W:0]            lvl_est;
    logic [QUOT_W:0]            lvl_rem;
    logic [1:0]                 lvl_fix;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [CFG_W:0]      mix_s;
    logic signed [MIXP_W-1:0]   mix_shift;

    // Offset sample, 0 .. 2*FULL_SCALE
    assign u_val = SAMPLE_W'(dry_reg) + SAMPLE_W'(FULL_SCALE);

    // Level = M / FULL_SCALE, M = (u*S + FULL_SCALE) / 2 held in num_reg.
    // 1/(2^15-1) is taken as 2^-15 + 2^-30: the estimate falls short by at
    // most two, and the remainder tells how many to add back.
    assign lvl_est = (QUOT_W+1)'(num_reg[2*SH:SH]) + (QUOT_W+1)'(num_reg[2*SH]);
    assign lvl_rem = (QUOT_W+1)'(num_reg[SH-1:0]) + (QUOT_W+1)'(num_reg[2*SH:SH])
                   - (num_reg[2*SH] ? (QUOT_W+1)'(FULL_SCALE) : (QUOT_W+1)'(0));
    assign lvl_fix = {1'b0, lvl_rem_reg >= (QUOT_W+1)'(FULL_SCALE)}
                   + {1'b0, lvl_rem_reg >= (QUOT_W+1)'(2 * FULL_SCALE)};

    // Divider operands: the reconstructed value
    assign div_start = (state_reg == L_DIV2S);
    assign div_numer = num_reg;
    assign div_denom = {job_reg.levels_m1, 1'b0};

    sbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Blend operands
    assign diff      = (SAMPLE_W+1)'(held_reg) - (SAMPLE_W+1)'(dry_reg);
    assign mix_s     = $signed({1'b0, job_reg.mix});
    assign mix_shift = mix_prod_reg >>> PH_FRAC;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:  if (start) state_next = job.capture ? L_MUL1 : L_MIX1;
            L_MUL1:  state_next = L_LVL1;
            L_LVL1:  state_next = L_LVL2;
            L_LVL2:  state_next = L_LVL3;
            L_LVL3:  state_next = L_MUL2;
            L_MUL2:  state_next = L_DIV2S;
            L_DIV2S: state_next = L_DIV2W;
            L_DIV2W: if (div_done) state_next = L_MIX1;
            L_MIX1:  state_next = L_MIX2;
            L_MIX2:  state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_MIX2);
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    dry_reg <= sample;
                    job_reg <= job;
                end
            end
            L_MUL1:  num_reg <= NUM_W'(32'(u_val) * 32'(job_reg.levels_m1));
            L_LVL1:  num_reg <= NUM_W'((num_reg + NUM_W'(FULL_SCALE)) >> 1);
            L_LVL2: begin
                lvl_est_reg <= lvl_est;
                lvl_rem_reg <= lvl_rem;
            end
            L_LVL3:  level_reg <= QUOT_W'(lvl_est_reg + (QUOT_W+1)'(lvl_fix));
            L_MUL2:  num_reg <= NUM_W'(level_reg) * NUM_W'(4 * FULL_SCALE)
                              + NUM_W'(job_reg.levels_m1);
            L_DIV2W: begin
                if (div_done) begin
                    held_reg <= SAMPLE_W'({1'b0, div_quot}
                                          - (QUOT_W+1)'(FULL_SCALE));
                end
            end
            L_MIX1:  mix_prod_reg <= MIXP_W'(diff) * MIXP_W'(mix_s)
                                   + MIXP_W'(2 ** (PH_FRAC - 1));
            L_MIX2:  result_reg <= SAMPLE_W'(mix_shift + MIXP_W'(dry_reg));
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/stereo_bitcrusher_top.sv
// On a held sample a request goes straight to the blend; when a fresh sample is
//   captured, each lane first runs the level estimate and the iterative division
//   before the blend.
// One request at a time: the next is taken only once the last pair is loaded out.
// A finished result waits in the output register while the next request runs.
// Reset (aresetn, synchronous, active low): registers to defaults, phase at
//   one, nothing held, output channel empty.
// ============================================================================
// stereo_bitcrusher_top : stereo sample-and-hold bitcrusher
// Phase accumulator and configuration, two channel lanes and the output
// register that merges their results into one pair.
// ============================================================================
module stereo_bitcrusher_top
    import sbc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    // Input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_in,
    input  logic signed [SAMPLE_W-1:0] s_right_in,
    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_left_out,
    output logic signed [SAMPLE_W-1:0] m_right_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_HOLD} top_state_t;

    top_state_t state_reg, state_next;

    logic [CFG_W-1:0]   inc_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [CFG_W-1:0]   mix_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               hold_valid_reg;
    logic               m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_left_reg;
    logic signed [SAMPLE_W-1:0] m_right_reg;

    logic               accept;
    logic               capture;
    logic               lanes_done;
    logic               load_out;
    logic [CFG_W-1:0]   inc_eff;
    logic [CFG_W-1:0]   mix_eff;
    logic [BITS_W-1:0]  bits_eff;
    logic [LEVELS_W:0]  levels_full;
    logic [PHASE_W-1:0] phase_base;
    sbc_job_t           job;

    logic signed [SAMPLE_W-1:0] lane_in   [NUM_LANES];
    logic signed [SAMPLE_W-1:0] lane_out  [NUM_LANES];
    logic [NUM_LANES-1:0]       lane_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Clamp configuration to its working range
    always_comb begin
        priority if (bits_reg == '0)                    bits_eff = BITS_W'(1);
        else if (bits_reg > BITS_W'(MAX_DEPTH))         bits_eff = BITS_W'(MAX_DEPTH);
        else                                            bits_eff = bits_reg;

        priority if (inc_reg == '0)   inc_eff = CFG_W'(1);
        else if (inc_reg > PH_ONE)    inc_eff = PH_ONE;
        else                          inc_eff = inc_reg;

        mix_eff = (mix_reg > PH_ONE) ? PH_ONE : mix_reg;
    end

    assign levels_full = (LEVELS_W+1)'(1) << bits_eff;

    // Capture when nothing is held yet or the phase has wrapped
    assign capture    = !hold_valid_reg || (phase_reg >= PHASE_W'(PH_ONE));
    assign phase_base = capture ? (phase_reg & PHASE_W'(PH_ONE - 1'b1)) : phase_reg;

    assign job.capture   = capture;
    assign job.levels_m1 = LEVELS_W'(levels_full - 1'b1);
    assign job.mix       = mix_eff;

    // Most negative code folds onto -FULL_SCALE
    assign lane_in[0] = (s_left_in == {1'b1, {(SAMPLE_W-1){1'b0}}})
                      ? -SAMPLE_W'(FULL_SCALE) : s_left_in;
    assign lane_in[1] = (s_right_in == {1'b1, {(SAMPLE_W-1){1'b0}}})
                      ? -SAMPLE_W'(FULL_SCALE) : s_right_in;

    // Channel lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        sbc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (accept),
            .job     (job),
            .sample  (lane_in[g]),
            .done    (lane_done[g]),
            .result  (lane_out[g])
        );
    end

    // Merge: both lanes finish together, pair goes to the output register once it is free
    assign lanes_done = &lane_done;
    assign load_out   = ((state_reg == ST_BUSY) && lanes_done
                         && (!m_valid_reg || m_ready))
                      || ((state_reg == ST_HOLD) && m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY: begin
                if (lanes_done) state_next = load_out ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            inc_reg        <= PH_ONE;
            bits_reg       <= BITS_W'(8);
            mix_reg        <= '0;
            phase_reg      <= PHASE_W'(PH_ONE);
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                phase_reg      <= phase_base + PHASE_W'(inc_eff);
                hold_valid_reg <= 1'b1;
            end

            // Rate or depth writes force a fresh capture
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PHASE_INC: begin
                        inc_reg   <= cfg_data;
                        phase_reg <= PHASE_W'(PH_ONE);
                    end
                    REG_CRUSH_BITS: begin
                        bits_reg  <= cfg_data[BITS_W-1:0];
                        phase_reg <= PHASE_W'(PH_ONE);
                    end
                    REG_MIX_AMOUNT: mix_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_left_reg  <= lane_out[0];
            m_right_reg <= lane_out[1];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

endmodule

>>> rtl/core/sbc_chk.sv
// ============================================================================
// sbc_chk : port-level checks for the stereo bitcrusher
// Watches the top level's channels and is bound to every instance of it.
// ============================================================================
module sbc_chk
    import sbc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [SAMPLE_W-1:0]  m_left_out,
    input logic [SAMPLE_W-1:0]  m_right_out
);

    localparam logic [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out) && $stable(m_right_out))
        else $error("result changed while stalled");

    // One request in flight: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one busy");

    // Blend stays within -FULL..+FULL
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_out != MOST_NEG) && (m_right_out != MOST_NEG))
        else $error("result outside sample range");

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stereo_bitcrusher_top sbc_chk u_sbc_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_out  (m_left_out),
    .m_right_out (m_right_out)
);

>>> verif/stereo_bitcrusher_top_tb.sv
// ============================================================================
// stereo_bitcrusher_top_tb : self-checking bench for the stereo bitcrusher
// Feeds stereo sample pairs under random handshake gaps and register
// settings, predicts every blended pair in step and compares each result.
// ============================================================================
module stereo_bitcrusher_top_tb;
    import sbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_FULL = SAMPLE_W'(FULL_SCALE);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_FULL = SAMPLE_W'(-FULL_SCALE);
    localparam int IDLE_MAX       = 12;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PAIR_TARGET    = 1450;
    localparam int PRINT_LIMIT    = 40;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_pair_t;

    // Block ports
    logic                       aclk;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_W-1:0]           cfg_data    = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_in   = '0;
    logic signed [SAMPLE_W-1:0] s_right_in  = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;

    // Request and result stores
    stereo_pair_t pending_pairs[$];
    stereo_pair_t expected_pairs[$];

    // Predicted block state and registers
    logic [CFG_W-1:0]           model_inc   = PH_ONE;
    logic [BITS_W-1:0]          model_bits  = BITS_W'(8);
    logic [CFG_W-1:0]           model_mix   = '0;
    logic [PHASE_W-1:0]         model_phase = PHASE_W'(PH_ONE);
    logic                       model_hold  = 1'b0;
    logic signed [SAMPLE_W-1:0] model_held_l = '0;
    logic signed [SAMPLE_W-1:0] model_held_r = '0;

    // Handshake knobs and counters
    int send_idle_max   = IDLE_MAX;
    int recv_idle_max   = IDLE_MAX;
    int send_gap        = 0;
    int recv_gap        = 0;
    int recv_stall      = 0;
    int holdoffs_wanted = 0;
    int holdoffs_done   = 0;
    int quiet_cycles    = 0;
    int mismatch_count  = 0;
    int pairs_queued    = 0;
    int pairs_sent      = 0;
    int pairs_checked   = 0;
    int reg_writes      = 0;
    int settings_used   = 0;

    stereo_bitcrusher_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic longint clamp_sample(input logic signed [SAMPLE_W-1:0] x);
        if (x < -FULL_SCALE)
            return -FULL_SCALE;
        return longint'(x);
    endfunction

    // Snap to 2^depth evenly spaced levels over -FULL..+FULL, round half up twice
    function automatic logic signed [SAMPLE_W-1:0] crush_sample(input longint x,
                                                                input logic [BITS_W-1:0] bits);
        longint depth, span, steps, u, level, q;
        depth = bits;
        if (depth < 1)
            depth = 1;
        if (depth > MAX_DEPTH)
            depth = MAX_DEPTH;
        span  = 2 * FULL_SCALE;
        steps = (longint'(1) << depth) - 1;
        u     = x + FULL_SCALE;
        level = (u * steps * 2 + span) / (2 * span);
        q     = (level * span * 2 + steps) / (2 * steps);
        return SAMPLE_W'(q - FULL_SCALE);
    endfunction

    // dry + (wet - dry) * mix, floor after adding a half
    function automatic logic signed [SAMPLE_W-1:0] blend_sample(input longint dry,
                                                                input longint wet,
                                                                input longint mix);
        longint t;
        t = (wet - dry) * mix + longint'(PH_ONE / 2);
        return SAMPLE_W'(dry + (t >>> PH_FRAC));
    endfunction

    task automatic predict_pair(input logic signed [SAMPLE_W-1:0] l_in,
                                input logic signed [SAMPLE_W-1:0] r_in);
        longint l, r, inc, mix;
        stereo_pair_t res;
        l   = clamp_sample(l_in);
        r   = clamp_sample(r_in);
        inc = model_inc;
        if (inc < 1)
            inc = 1;
        if (inc > longint'(PH_ONE))
            inc = PH_ONE;
        mix = (model_mix > PH_ONE) ? longint'(PH_ONE) : longint'(model_mix);
        // fresh capture when nothing held or the phase has wrapped
        if (!model_hold || model_phase >= PH_ONE) begin
            model_held_l = crush_sample(l, model_bits);
            model_held_r = crush_sample(r, model_bits);
            model_hold   = 1'b1;
            model_phase  = model_phase & PHASE_W'(PH_ONE - 1);
        end
        model_phase = PHASE_W'(model_phase + inc);
        res.left  = blend_sample(l, model_held_l, mix);
        res.right = blend_sample(r, model_held_r, mix);
        expected_pairs.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: one request per queued pair, random gap after each
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : pair_driver
        stereo_pair_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pair(s_left_in, s_right_in);
                pairs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    nxt = pending_pairs.pop_front();
                    s_left_in  <= nxt.left;
                    s_right_in <= nxt.right;
                    s_valid    <= 1'b1;
                    send_gap   <= $urandom_range(0, send_idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result, draws its own ready gaps, runs the requested hold-offs
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        stereo_pair_t want;
        int           g;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_gap   <= 0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                pairs_checked++;
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                              m_left_out, m_right_out));
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_left_out !== want.left)
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  m_left_out, want.left));
                    if (m_right_out !== want.right)
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  m_right_out, want.right));
                end
            end
            if (holdoffs_done != holdoffs_wanted) begin
                holdoffs_done <= holdoffs_done + 1;
                recv_stall    <= HOLDOFF_CYCLES;
                m_ready       <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (m_valid && m_ready) begin
                g = $urandom_range(0, recv_idle_max);
                recv_gap <= g;
                m_ready  <= (g == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= (recv_gap == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any request or result moving
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, quiet_cycles);
            $display("stereo_bitcrusher_top_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_pair(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        stereo_pair_t p;
        p.left  = l;
        p.right = r;
        pending_pairs.push_back(p);
        pairs_queued++;
    endtask

    // only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PHASE_INC: begin
                model_inc   = val;
                model_phase = PHASE_W'(PH_ONE);
            end
            REG_CRUSH_BITS: begin
                model_bits  = val[BITS_W-1:0];
                model_phase = PHASE_W'(PH_ONE);
            end
            REG_MIX_AMOUNT: model_mix = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_until_drained();
        do
            @(posedge aclk);
        while (pending_pairs.size() != 0 || s_valid || expected_pairs.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_POS_FULL;
            2: return SAMPLE_NEG_FULL;
            3: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_W-1:0] val;
        int               n;
        int               phase_no;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: mix of zero passes the dry signal
        settings_used++;
        queue_pair(SAMPLE_POS_FULL, SAMPLE_MIN);
        queue_pair(SAMPLE_NEG_FULL, 16'sd12345);
        queue_pair('0, -16'sd1);
        wait_until_drained();

        // full wet at 16 bits: input extremes and clamp of most negative value
        write_reg(REG_MIX_AMOUNT, PH_ONE);
        write_reg(REG_CRUSH_BITS, CFG_W'(16));
        write_reg(REG_PHASE_INC, PH_ONE);
        settings_used++;
        queue_pair(SAMPLE_MIN, SAMPLE_POS_FULL);
        queue_pair(SAMPLE_NEG_FULL, '0);
        queue_pair(16'sd1, -16'sd1);
        queue_pair(16'sh5555, 16'shAAAA);
        queue_pair(16'sd16383, -16'sd16384);
        wait_until_drained();

        // one bit: two levels only
        write_reg(REG_CRUSH_BITS, CFG_W'(1));
        settings_used++;
        queue_pair(SAMPLE_POS_FULL, SAMPLE_NEG_FULL);
        queue_pair(16'sd100, -16'sd100);
        queue_pair('0, '0);
        wait_until_drained();

        // depth out of range on both sides
        write_reg(REG_CRUSH_BITS, CFG_W'(0));
        queue_pair(16'sd20000, -16'sd20000);
        wait_until_drained();
        write_reg(REG_CRUSH_BITS, CFG_W'(31));
        queue_pair(SAMPLE_MIN, -16'sd2);
        wait_until_drained();

        // unknown register index leaves everything alone
        write_reg(REG_UNUSED, CFG_W'(5));
        queue_pair(16'sd3, 16'sd30000);
        wait_until_drained();

        // zero increment acts as one, oversized mix acts as full wet
        write_reg(REG_PHASE_INC, '0);
        write_reg(REG_MIX_AMOUNT, '1);
        write_reg(REG_CRUSH_BITS, CFG_W'(4));
        settings_used++;
        queue_pair(16'sd9000, -16'sd9000);
        queue_pair(16'sd31000, -16'sd31000);
        queue_pair(-16'sd5, 16'sd5);
        wait_until_drained();

        // half rate with half mix: capture every other pair, half-way rounding
        write_reg(REG_PHASE_INC, CFG_W'(PH_ONE / 2));
        write_reg(REG_MIX_AMOUNT, CFG_W'(PH_ONE / 2));
        settings_used++;
        repeat (4) queue_pair(pick_sample(), pick_sample());
        wait_until_drained();

        // smallest mix step
        write_reg(REG_MIX_AMOUNT, CFG_W'(1));
        queue_pair(SAMPLE_POS_FULL, SAMPLE_NEG_FULL);
        wait_until_drained();

        // random settings and samples
        phase_no = 0;
        while (pairs_queued < PAIR_TARGET) begin
            phase_no++;
            settings_used++;
            send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
            recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;

            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 6))
                    0: val = PH_ONE;
                    1: val = CFG_W'(1);
                    2: val = '0;
                    3: val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
                    4: val = CFG_W'($urandom_range(1, 64));
                    5: val = CFG_W'($urandom_range(PH_ONE / 2, PH_ONE));
                    default: val = CFG_W'($urandom_range(1, PH_ONE));
                endcase
                write_reg(REG_PHASE_INC, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 3) == 0)
                    val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
                else
                    val = CFG_W'($urandom_range(0, 31));
                write_reg(REG_CRUSH_BITS, val);
            end
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 4))
                    0: val = '0;
                    1: val = PH_ONE;
                    2: val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
                    default: val = CFG_W'($urandom_range(0, PH_ONE));
                endcase
                write_reg(REG_MIX_AMOUNT, val);
            end

            // output side holds off while the sender keeps pushing: fills the block
            if (phase_no == 3) begin
                send_idle_max = 0;
                holdoffs_wanted++;
                n = 40;
            end else begin
                n = $urandom_range(8, 60);
            end
            repeat (n) queue_pair(pick_sample(), pick_sample());

            // occasional mid-phase pause until every result is back
            if ($urandom_range(0, 4) == 0) begin
                wait_until_drained();
                repeat ($urandom_range(4, 20)) queue_pair(pick_sample(), pick_sample());
            end
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_pairs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pairs.size()));

        $display("summary: %0d pairs sent, %0d results checked, %0d register writes, %0d settings",
                 pairs_sent, pairs_checked, reg_writes, settings_used);
        $display("summary: captures and holds at many rates and depths, %s, %0d mismatches",
                 "long output hold-off", mismatch_count);
        if (mismatch_count == 0) begin
            $display("stereo_bitcrusher_top_tb: clean");
        end else begin
            $display("stereo_bitcrusher_top_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_div.sv
rtl/core/sbc_lane.sv
rtl/core/stereo_bitcrusher_top.sv
rtl/core/sbc_chk.sv
verif/stereo_bitcrusher_top_tb.sv
